// File: design/ple_pkg.sv
// Shared types and constants of the positional list engine.
// Used by ple_cell and positional_list_engine_core; no dependencies.
`default_nettype none

package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_DUMP_FWD  = 3'd6,
    ACT_DUMP_BACK = 3'd7
  } action_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_ROTL   = 3'd3,
    OP_ROTR   = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          slot;
    logic signed [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: design/positional_list_engine_core.sv
// Top level of the positional list engine: request control and the cell ring.
// Depends on ple_pkg and ple_cell.
`default_nettype none

// An ordered list of up to CAPACITY signed 32-bit values kept in a ring of
// cells, slot 0 at the front. On an insert or delete every cell shifts
// toward or away from the target slot at once, and the single result is
// registered. A dump of a non-empty list rotates the whole ring one cell per
// cycle while the output side does not stall, through all CAPACITY slots,
// emitting an element on each step that lands on a listed slot; the ring is
// back in place when it ends. An empty dump and every other request give a
// single result. A new item is taken once the previous one has finished and
// its last result has been taken or is being taken.
module positional_list_engine_core (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [2:0]                          action,
  input  wire signed [ple_pkg::DATA_W-1:0]   value,
  input  wire [6:0]                          position,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [ple_pkg::DATA_W-1:0]  element,
  output logic [1:0]                         status,
  output logic [6:0]                         length,
  output logic                               last
);
  import ple_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                    state, state_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [IDX_W-1:0]          step, step_next;
  logic                      backward, backward_next;
  cell_cmd_t                 cmd;
  logic signed [DATA_W-1:0]  cell_data [CAPACITY];

  logic                      out_free;
  logic                      in_fire;
  logic                      advance;
  logic                      load_out;
  logic signed [DATA_W-1:0]  element_next;
  logic [1:0]                status_next;
  logic                      last_next;
  logic                      full;
  logic                      empty;
  logic [7:0]                pos_w;
  logic [7:0]                cnt_w;
  logic [CNT_W-1:0]          step_w;
  logic                      emit;
  logic                      step_end;
  action_t                   act;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      ple_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .index      (IDX_W'(g)),
        .left_data  (cell_data[(g + CAPACITY - 1) % CAPACITY]),
        .right_data (cell_data[(g + 1) % CAPACITY]),
        .data       (cell_data[g])
      );
    end
  endgenerate

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign advance  = (state == S_DUMP) && out_free;
  assign act      = action_t'(action);
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign pos_w    = {1'b0, position};
  assign cnt_w    = 8'(count);
  assign step_w   = CNT_W'(step);
  assign step_end = (step == IDX_W'(CAPACITY - 1));

  always_comb begin
    emit = 1'b0;
    if (backward) begin
      emit = step_w >= (CNT_W'(CAPACITY) - count);
    end else begin
      emit = step_w < count;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    step_next     = step;
    backward_next = backward;
    cmd.op        = OP_HOLD;
    cmd.slot      = '0;
    cmd.value     = value;
    load_out      = 1'b0;
    element_next  = '0;
    status_next   = ST_OK;
    last_next     = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          case (act)
            ACT_INS_FRONT, ACT_INS_BACK: begin
              if (full) begin
                status_next = ST_FULL;
              end else begin
                cmd.op     = OP_INSERT;
                cmd.slot   = (act == ACT_INS_FRONT) ? '0 : IDX_W'(count);
                count_next = count + 1'b1;
              end
            end
            ACT_INS_POS: begin
              if (pos_w == 8'd0 || pos_w > cnt_w + 8'd1) begin
                status_next = ST_INVALID;
              end else if (full) begin
                status_next = ST_FULL;
              end else begin
                cmd.op     = OP_INSERT;
                cmd.slot   = IDX_W'(pos_w - 8'd1);
                count_next = count + 1'b1;
              end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                cmd.op     = OP_DELETE;
                cmd.slot   = (act == ACT_DEL_FRONT) ? '0 : IDX_W'(count - 1'b1);
                count_next = count - 1'b1;
              end
            end
            ACT_DEL_POS: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else if (pos_w == 8'd0 || pos_w > cnt_w) begin
                status_next = ST_INVALID;
              end else begin
                cmd.op     = OP_DELETE;
                cmd.slot   = IDX_W'(pos_w - 8'd1);
                count_next = count - 1'b1;
              end
            end
            default: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                load_out      = 1'b0;
                state_next    = S_DUMP;
                step_next     = '0;
                backward_next = (act == ACT_DUMP_BACK);
              end
            end
          endcase
        end
      end
      S_DUMP: begin
        if (advance) begin
          cmd.op       = backward ? OP_ROTR : OP_ROTL;
          load_out     = emit;
          element_next = backward ? cell_data[CAPACITY-1] : cell_data[0];
          last_next    = backward ? step_end : (step_w == count - 1'b1);
          step_next    = step + 1'b1;
          if (step_end) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      step      <= '0;
      backward  <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      step     <= step_next;
      backward <= backward_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      element <= element_next;
      status  <= status_next;
      length  <= 7'(count_next);
      last    <= last_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_dump_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |=> $stable(count))
    else $error("element count changed during dump");

  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && step_end) |=> (state == S_IDLE))
    else $error("dump did not finish after full rotation");

  a_dump_status_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP && out_valid) |-> (status == ST_OK))
    else $error("dump result with non-ok status");
`endif

endmodule

`default_nettype wire

// File: design/ple_cell.sv
// One storage cell of the list chain: holds one element slot.
// Depends on ple_pkg for the command struct and widths.
`default_nettype none

module ple_cell (
  input  wire                                    clk,
  input  ple_pkg::cell_cmd_t                     cmd,
  input  wire [ple_pkg::IDX_W-1:0]               index,
  input  wire signed [ple_pkg::DATA_W-1:0]       left_data,
  input  wire signed [ple_pkg::DATA_W-1:0]       right_data,
  output logic signed [ple_pkg::DATA_W-1:0]      data
);
  import ple_pkg::*;

  logic signed [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.op)
      OP_HOLD: data_next = data;
      OP_INSERT: begin
        if (index > cmd.slot) begin
          data_next = left_data;
        end else if (index == cmd.slot) begin
          data_next = cmd.value;
        end
      end
      OP_DELETE: begin
        if (index >= cmd.slot) begin
          data_next = right_data;
        end
      end
      OP_ROTL: data_next = right_data;
      OP_ROTR: data_next = left_data;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire
